// ===== src/ilist_pkg.sv =====
// Shared constants, codes and types for the indexed list block.
`timescale 1ns / 1ps

package ilist_pkg;

    // Store geometry
    localparam int DEPTH    = 64;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Beat field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int TOL_W    = 31;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NOMATCH = 2'd3;

    // Command broadcast to every cell for one execute cycle
    typedef struct packed {
        logic                      exec;       // execute cycle: capture hit and removed entry
        logic                      load;       // write value at pos
        logic                      shift_up;   // cells above pos take left neighbor
        logic                      shift_down; // cells at or above pos take right neighbor
        logic                      search;     // compute hit flags
        logic [IDX_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
        logic [TOL_W-1:0]          tol;
        logic [CNT_W-1:0]          cnt;
    } cell_cmd_t;

endpackage

// ===== src/ilist_cell.sv =====
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
`timescale 1ns / 1ps

module ilist_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ilist_pkg::IDX_W-1:0]         cell_idx,
    input  ilist_pkg::cell_cmd_t                cmd,
    input  logic signed [ilist_pkg::VALUE_W-1:0] left_data,
    input  logic signed [ilist_pkg::VALUE_W-1:0] right_data,
    output logic signed [ilist_pkg::VALUE_W-1:0] entry_out,
    output logic                                hit_out,
    output logic signed [ilist_pkg::VALUE_W-1:0] sel_out
);

    logic signed [ilist_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic                                 hit_reg, hit_next;
    logic signed [ilist_pkg::VALUE_W-1:0] sel_reg, sel_next;
    logic                                 at_pos, above_pos, in_list;
    logic signed [ilist_pkg::VALUE_W:0]   diff;
    logic [ilist_pkg::VALUE_W:0]          abs_diff;

    assign at_pos    = (cell_idx == cmd.pos);
    assign above_pos = (cell_idx > cmd.pos);
    assign in_list   = ({{(ilist_pkg::CNT_W - ilist_pkg::IDX_W){1'b0}}, cell_idx} < cmd.cnt);

    // Exact difference to the probe value, one bit wider than an entry
    assign diff     = {entry_reg[ilist_pkg::VALUE_W-1], entry_reg}
                    - {cmd.value[ilist_pkg::VALUE_W-1], cmd.value};
    assign abs_diff = diff[ilist_pkg::VALUE_W] ? (~diff + 1'b1) : diff;

    // Pick the next entry: load beats shift at the target slot
    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_up && above_pos) begin
            entry_next = left_data;
        end
        if (cmd.shift_down && (at_pos || above_pos)) begin
            entry_next = right_data;
        end
        if (cmd.load && at_pos) begin
            entry_next = cmd.value;
        end
    end

    // Capture search hit and the entry leaving on delete
    always_comb begin
        hit_next = cmd.search && in_list
                 && (abs_diff < {{(ilist_pkg::VALUE_W + 1 - ilist_pkg::TOL_W){1'b0}}, cmd.tol});
        sel_next = (cmd.shift_down && at_pos) ? entry_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    // Hold hit and removed entry until the next execute cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            hit_reg <= hit_next;
            sel_reg <= sel_next;
        end
    end

    assign entry_out = entry_reg;
    assign hit_out   = hit_reg;
    assign sel_out   = sel_reg;

endmodule

// ===== src/ilist_pick.sv =====
// Collects cell flags: lowest hit index and the entry taken out by a delete.
`timescale 1ns / 1ps

module ilist_pick (
    input  logic [ilist_pkg::DEPTH-1:0]                        hit_vec,
    input  logic [ilist_pkg::DEPTH-1:0][ilist_pkg::VALUE_W-1:0] sel_vec,
    output logic                                               any_hit,
    output logic [ilist_pkg::IDX_W-1:0]                        first_idx,
    output logic [ilist_pkg::VALUE_W-1:0]                      removed
);

    // Priority encode toward the lowest index
    always_comb begin
        first_idx = '0;
        for (int i = ilist_pkg::DEPTH - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                first_idx = ilist_pkg::IDX_W'(i);
            end
        end
    end

    assign any_hit = |hit_vec;

    // Only the deleted slot drives a nonzero value
    always_comb begin
        removed = '0;
        for (int i = 0; i < ilist_pkg::DEPTH; i++) begin
            removed = removed | sel_vec[i];
        end
    end

endmodule

// ===== src/indexed_list_insert_delete_search.sv =====
// Top level of the indexed list: handshake, command decode, cell row and result register.
`timescale 1ns / 1ps

// Indexed list with append, insert, delete and search on signed Q16.16 values.
// Input channel s_*: one beat per operation; s_tdata carries operation,
// position, item_value and tolerance. Result channel m_*: exactly one beat
// per operation with status, removed_value, match_index and entry_count.
// The store is a row of 64 cells; insert and delete move every cell at or
// above the position by one slot toward its neighbor, all together in the
// execute step, and search compares all cells at once.
// The result beat shows on m_tvalid after the execute step in the cells,
// the pick step (first hit and removed entry) and the output register.
// Each operation runs to the end of the pick step before the next beat
// is taken.
// Reset (aresetn low, synchronous) clears all slots to zero and the count.
// When the receiver stalls, the result is held in the output register and
// one more beat can be accepted and executed; its result waits in the pick
// step until the output register frees.

module indexed_list_insert_delete_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [7:2] position, [39:8] item_value, [70:40] tolerance, [71] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] removed_value, [39:34] match_index, [46:40] entry_count,
    // [47] zero
    output logic [47:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIND = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Captured operation
    logic [ilist_pkg::OP_W-1:0]    op_reg;
    logic [ilist_pkg::POS_W-1:0]   pos_reg;
    logic signed [ilist_pkg::VALUE_W-1:0] val_reg;
    logic [ilist_pkg::TOL_W-1:0]   tol_reg;

    logic [ilist_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ilist_pkg::STATUS_W-1:0] sts_reg, sts_next;

    // Result register
    logic                           m_valid_reg, m_valid_next;
    logic [ilist_pkg::STATUS_W-1:0] o_status_reg, o_status_next;
    logic [ilist_pkg::VALUE_W-1:0]  o_removed_reg, o_removed_next;
    logic [ilist_pkg::IDX_W-1:0]    o_match_reg, o_match_next;
    logic [ilist_pkg::CNT_W-1:0]    o_count_reg, o_count_next;

    ilist_pkg::cell_cmd_t cmd;
    logic                 s_beat, out_free;
    logic                 full;
    logic [ilist_pkg::CNT_W-1:0] pos_ext;

    logic [ilist_pkg::DEPTH-1:0][ilist_pkg::VALUE_W-1:0] ent_vec;
    logic [ilist_pkg::DEPTH-1:0][ilist_pkg::VALUE_W-1:0] sel_vec;
    logic [ilist_pkg::DEPTH-1:0]                         hit_vec;

    logic                          any_hit;
    logic [ilist_pkg::IDX_W-1:0]   first_idx;
    logic [ilist_pkg::VALUE_W-1:0] removed;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (cnt_reg == ilist_pkg::CNT_W'(ilist_pkg::DEPTH));
    assign pos_ext  = ilist_pkg::CNT_W'(pos_reg);

    // Decode the operation into a cell command and the new count
    always_comb begin
        cmd        = '0;
        cmd.pos    = pos_reg[ilist_pkg::IDX_W-1:0];
        cmd.value  = val_reg;
        cmd.tol    = tol_reg;
        cmd.cnt    = cnt_reg;
        cnt_next   = cnt_reg;
        sts_next   = sts_reg;
        if (state_reg == ST_EXEC) begin
            cmd.exec = 1'b1;
            sts_next = ilist_pkg::STS_OK;
            case (op_reg)
                ilist_pkg::OP_APPEND: begin
                    if (full) begin
                        sts_next = ilist_pkg::STS_FULL;
                    end else begin
                        cmd.load = 1'b1;
                        cmd.pos  = cnt_reg[ilist_pkg::IDX_W-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ilist_pkg::OP_INSERT: begin
                    if (full || (pos_ext >= ilist_pkg::CNT_W'(ilist_pkg::DEPTH))) begin
                        sts_next = ilist_pkg::STS_FULL;
                    end else if (pos_ext < cnt_reg) begin
                        cmd.load     = 1'b1;
                        cmd.shift_up = 1'b1;
                        cnt_next     = cnt_reg + 1'b1;
                    end else begin
                        // Gap slots already hold zero
                        cmd.load = 1'b1;
                        cnt_next = pos_ext + 1'b1;
                    end
                end
                ilist_pkg::OP_DELETE: begin
                    if (pos_ext >= cnt_reg) begin
                        sts_next = ilist_pkg::STS_ABSENT;
                    end else begin
                        cmd.shift_down = 1'b1;
                        cnt_next       = cnt_reg - 1'b1;
                    end
                end
                ilist_pkg::OP_SEARCH: begin
                    cmd.search = 1'b1;
                end
                default: begin
                    sts_next = ilist_pkg::STS_OK;
                end
            endcase
        end
    end

    // Row of cells, each fed by both neighbors
    genvar g;
    generate
        for (g = 0; g < ilist_pkg::DEPTH; g++) begin : g_cell
            localparam int unsigned CellNum = g;
            logic [ilist_pkg::IDX_W-1:0]          idx_w;
            logic signed [ilist_pkg::VALUE_W-1:0] left_w, right_w;

            assign idx_w = CellNum[ilist_pkg::IDX_W-1:0];
            if (g == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = ent_vec[g-1];
            end
            if (g == ilist_pkg::DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = ent_vec[g+1];
            end

            ilist_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_idx   (idx_w),
                .cmd        (cmd),
                .left_data  (left_w),
                .right_data (right_w),
                .entry_out  (ent_vec[g]),
                .hit_out    (hit_vec[g]),
                .sel_out    (sel_vec[g])
            );
        end
    endgenerate

    ilist_pick u_pick (
        .hit_vec   (hit_vec),
        .sel_vec   (sel_vec),
        .any_hit   (any_hit),
        .first_idx (first_idx),
        .removed   (removed)
    );

    // Sequence the operation and load the result register
    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        o_status_next  = o_status_reg;
        o_removed_next = o_removed_reg;
        o_match_next   = o_match_reg;
        o_count_next   = o_count_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FIND;
            end
            ST_FIND: begin
                if (out_free) begin
                    state_next     = ST_IDLE;
                    m_valid_next   = 1'b1;
                    o_status_next  = sts_reg;
                    o_removed_next = '0;
                    o_match_next   = '0;
                    o_count_next   = cnt_reg;
                    if (op_reg == ilist_pkg::OP_DELETE) begin
                        o_removed_next = removed;
                    end
                    if (op_reg == ilist_pkg::OP_SEARCH) begin
                        if (any_hit) begin
                            o_match_next = first_idx;
                        end else begin
                            o_status_next = ilist_pkg::STS_NOMATCH;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload: captured operation and result fields
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg  <= s_tdata[1:0];
            pos_reg <= s_tdata[7:2];
            val_reg <= s_tdata[39:8];
            tol_reg <= s_tdata[70:40];
        end
        sts_reg       <= sts_next;
        o_status_reg  <= o_status_next;
        o_removed_reg <= o_removed_next;
        o_match_reg   <= o_match_next;
        o_count_reg   <= o_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_count_reg, o_match_reg, o_removed_reg, o_status_reg};

`ifndef SYNTHESIS
    // The count never passes the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ilist_pkg::CNT_W'(ilist_pkg::DEPTH))
        else $error("entry count above capacity");

    // The count only moves in the execute cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EXEC) |=> $stable(cnt_reg))
        else $error("entry count changed outside execute");

    // A failed search reports index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (o_status_reg == ilist_pkg::STS_NOMATCH)) |-> (o_match_reg == '0))
        else $error("no-match result with nonzero index");

    // A rejected delete returns no value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (o_status_reg == ilist_pkg::STS_ABSENT)) |-> (o_removed_reg == '0))
        else $error("absent result with nonzero removed value");
`endif

endmodule
